>>> rtl/core/jseu_pkg.sv
`default_nettype none

package jseu_pkg;

  // what one slot of the emit buffer expands into
  typedef enum logic [4:0] {
    TK_RAW   = 5'b00001,
    TK_BSL   = 5'b00010,
    TK_ESC   = 5'b00100,
    TK_OPEN  = 5'b01000,
    TK_CLOSE = 5'b10000
  } tok_kind_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h57;  // 'a' - 10

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] LEAD2_LO   = 8'hc2;
  localparam logic [7:0] LEAD2_HI   = 8'hdf;
  localparam logic [7:0] LEAD3_LO   = 8'he0;
  localparam logic [7:0] LEAD3_HI   = 8'hef;
  localparam logic [7:0] LEAD4_LO   = 8'hf0;
  localparam logic [7:0] LEAD4_HI   = 8'hf4;
  localparam logic [7:0] LEAD_SURR  = 8'hed;
  localparam logic [7:0] CONT_MASK  = 8'hc0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] LIM_A0     = 8'ha0;
  localparam logic [7:0] LIM_90     = 8'h90;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    return (nib < 4'd10) ? (CH_ZERO + wide) : (CH_ALPHA + wide);
  endfunction

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
    else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
    else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
    return len;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/json_string_escape_utf8.sv
// json_string_escape_utf8: turns the raw bytes of a string into a JSON string
// literal with utf-8 checking, one output byte per cycle while out_ready does not stall.
// input channel: in_valid/in_ready, func (0 data byte, 1 end of string) and
// in_byte. output channel: out_valid/out_ready, out_byte, last (final byte
// caused by that input item) and closing (the closing quote).
// an accepted item is expanded at once into at most five slots (opening quote,
// up to three held bytes, one new byte or the closing quote) in an emit
// buffer; a walker steps through the slots and fills the output register.
// the first byte of an item passes from the emit buffer into the output
// register before it shows on out_valid. the bytes of an item leave one at a
// time, set by the single output byte lane; the next item is taken in the
// cycle the last byte of the previous one moves to the output register.
// items that only hold a byte of a multi-byte sequence yield nothing but a
// possible opening quote, and in_ready stays high when the buffer is left empty.
// reset clears the buffer, the output valid bit and the hold state; the next
// byte starts a new string. a stall on out_ready holds the output register and
// the buffer, and in_ready stays low while the buffer holds slots it cannot drain.
`default_nettype none

module json_string_escape_utf8
  import jseu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       func,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            closing
);

  localparam int Slots = 5;

  // string state
  logic           opened, opened_next;
  logic [7:0]     held [3];
  logic [7:0]     held_next [3];
  logic [1:0]     held_count, held_count_next;
  logic [2:0]     seq_len, seq_len_next;

  // emit buffer
  logic [Slots-1:0] tok_v;
  tok_kind_t        tok_k [Slots];
  logic [7:0]       tok_b [Slots];
  logic [2:0]       sub;

  logic [Slots-1:0] plan_v;
  tok_kind_t        plan_k [Slots];
  logic [7:0]       plan_b [Slots];

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // expansion of one item against the current hold state
  always_comb begin
    logic do_fresh;
    logic cont;
    logic bad;
    logic [2:0] len;
    do_fresh        = 1'b0;
    opened_next     = 1'b1;
    held_count_next = held_count;
    seq_len_next    = seq_len;
    held_next       = held;
    plan_v          = '0;
    for (int i = 0; i < Slots; i++) begin
      plan_k[i] = TK_RAW;
      plan_b[i] = in_byte;
    end
    plan_v[0] = !opened;
    plan_k[0] = TK_OPEN;

    bad = (held[0] == LEAD3_LO && in_byte < LIM_A0) ||
          (held[0] == LEAD_SURR && in_byte >= LIM_A0) ||
          (held[0] == LEAD4_LO && in_byte < LIM_90) ||
          (held[0] == LEAD4_HI && in_byte >= LIM_90);
    cont = ((in_byte & CONT_MASK) == CONT_TAG) && ((held_count != 2'd1) || !bad);

    if (func) begin
      for (int k = 0; k < 3; k++) begin
        if (k < int'(held_count)) begin
          plan_v[k+1] = 1'b1;
          plan_k[k+1] = TK_ESC;
          plan_b[k+1] = held[k];
        end
      end
      plan_v[4]       = 1'b1;
      plan_k[4]       = TK_CLOSE;
      opened_next     = 1'b0;
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
    end else if (seq_len == 3'd0 || held_count == 2'd0) begin
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
      do_fresh        = 1'b1;
    end else if (cont) begin
      if (({1'b0, held_count} + 3'd1) >= seq_len) begin
        // sequence complete: pass it through as is
        for (int k = 0; k < 3; k++) begin
          if (k < int'(held_count)) begin
            plan_v[k+1] = 1'b1;
            plan_k[k+1] = TK_RAW;
            plan_b[k+1] = held[k];
          end
        end
        plan_v[4]       = 1'b1;
        plan_k[4]       = TK_RAW;
        held_count_next = 2'd0;
        seq_len_next    = 3'd0;
      end else begin
        held_next[held_count] = in_byte;
        held_count_next       = held_count + 2'd1;
      end
    end else begin
      // broken sequence: escape what is held, then take the byte afresh
      for (int k = 0; k < 3; k++) begin
        if (k < int'(held_count)) begin
          plan_v[k+1] = 1'b1;
          plan_k[k+1] = TK_ESC;
          plan_b[k+1] = held[k];
        end
      end
      held_count_next = 2'd0;
      seq_len_next    = 3'd0;
      do_fresh        = 1'b1;
    end

    len = lead_len(in_byte);
    if (do_fresh) begin
      if (in_byte >= CONT_TAG) begin
        if (len != 3'd0) begin
          held_next[0]    = in_byte;
          held_count_next = 2'd1;
          seq_len_next    = len;
        end else begin
          plan_v[4] = 1'b1;
          plan_k[4] = TK_ESC;
        end
      end else if (in_byte == CH_QUOTE || in_byte == CH_BSL) begin
        plan_v[4] = 1'b1;
        plan_k[4] = TK_BSL;
      end else if (in_byte < CTRL_LIMIT) begin
        plan_v[4] = 1'b1;
        plan_k[4] = TK_ESC;
      end else begin
        plan_v[4] = 1'b1;
        plan_k[4] = TK_RAW;
      end
    end
  end

  // walker over the emit buffer
  logic [2:0]       cur;
  logic [Slots-1:0] rest;
  logic [2:0]       cur_len;
  logic [7:0]       cur_char;
  logic             last_sub, buf_last, advance, busy;

  always_comb begin
    logic found;
    found = 1'b0;
    cur   = 3'd0;
    for (int i = 0; i < Slots; i++) begin
      if (tok_v[i] && !found) begin
        found = 1'b1;
        cur   = 3'(i);
      end
    end
  end

  always_comb begin
    rest      = tok_v;
    rest[cur] = 1'b0;
  end

  always_comb begin
    unique case (tok_k[cur])
      TK_RAW:   cur_len = 3'd1;
      TK_BSL:   cur_len = 3'd2;
      TK_ESC:   cur_len = 3'd6;
      TK_OPEN:  cur_len = 3'd1;
      TK_CLOSE: cur_len = 3'd1;
      default:  cur_len = 3'd1;
    endcase
  end

  always_comb begin
    cur_char = CH_QUOTE;
    unique case (tok_k[cur])
      TK_RAW:   cur_char = tok_b[cur];
      TK_BSL:   cur_char = (sub == 3'd0) ? CH_BSL : tok_b[cur];
      TK_ESC: begin
        case (sub)
          3'd0:    cur_char = CH_BSL;
          3'd1:    cur_char = CH_U;
          3'd4:    cur_char = hex_char(tok_b[cur][7:4]);
          3'd5:    cur_char = hex_char(tok_b[cur][3:0]);
          default: cur_char = CH_ZERO;
        endcase
      end
      TK_OPEN:  cur_char = CH_QUOTE;
      TK_CLOSE: cur_char = CH_QUOTE;
      default:  cur_char = CH_QUOTE;
    endcase
  end

  assign busy     = |tok_v;
  assign last_sub = (sub == (cur_len - 3'd1));
  assign buf_last = (rest == '0) && last_sub;
  assign advance  = busy && (!out_valid || out_ready);
  assign in_ready = !busy || (advance && buf_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_v      <= '0;
      sub        <= 3'd0;
      out_valid  <= 1'b0;
      opened     <= 1'b0;
      held_count <= 2'd0;
      seq_len    <= 3'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        if (last_sub) begin
          tok_v[cur] <= 1'b0;
          sub        <= 3'd0;
        end else begin
          sub <= sub + 3'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        tok_v      <= plan_v;
        sub        <= 3'd0;
        opened     <= opened_next;
        held_count <= held_count_next;
        seq_len    <= seq_len_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte <= cur_char;
      last     <= buf_last;
      closing  <= (tok_k[cur] == TK_CLOSE);
    end
    if (in_acc) begin
      held   <= held_next;
      tok_k  <= plan_k;
      tok_b  <= plan_b;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/json_string_escape_utf8_checker.sv
`default_nettype none

module json_string_escape_utf8_checker
  import jseu_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       last,
  input wire logic       closing
);

  // the closing quote always ends the bytes of its item
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && closing |-> last)
    else $error("closing byte without last");

  a_close_quote: assert property (@(posedge clk) disable iff (rst)
    out_valid && closing |-> out_byte == CH_QUOTE)
    else $error("closing byte is not a quote");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last)
      && $stable(closing))
    else $error("stalled result changed");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind json_string_escape_utf8 json_string_escape_utf8_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .last      (last),
  .closing   (closing)
);

`default_nettype wire

>>> tb/tb_json_string_escape_utf8.sv
`default_nettype none

module tb_json_string_escape_utf8;
  import jseu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FN_DATA = 1'b0;
  localparam logic FN_END  = 1'b1;

  localparam int RANDOM_ITEMS = 83;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 16;

  typedef struct packed {
    logic       fn;
    logic [7:0] data;
  } str_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       closing;
  } lit_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       func = FN_DATA;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last;
  logic       closing;

  str_item_t pending_items[$];
  lit_byte_t literal_q[$];
  lit_byte_t step_q[$];

  // encoder state as seen from outside
  logic        str_open = 1'b0;
  logic [7:0]  hold [3];
  int unsigned hold_cnt = 0;
  int unsigned seq_need = 0;

  int n_errors  = 0;
  int n_in      = 0;
  int n_strings = 0;
  int n_checked = 0;
  int cyc       = 0;
  int quiet_cnt = 0;
  logic calm;

  json_string_escape_utf8 uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .last     (last),
    .closing  (closing)
  );

  always #1 clk = ~clk;

  // long stretch without any idling on either side
  assign calm = (cyc >= 150) && (cyc < 450);

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    logic [7:0] w;
    w = {4'h0, n};
    if (n < 4'd10) return CH_ZERO + w;
    return 8'h61 + w - 8'd10;
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic cl);
    lit_byte_t r;
    r.b = b;
    r.last = 1'b0;
    r.closing = cl;
    step_q.push_back(r);
  endtask

  task automatic put_uesc(input logic [7:0] b);
    put_byte(CH_BSL, 1'b0);
    put_byte(CH_U, 1'b0);
    put_byte(CH_ZERO, 1'b0);
    put_byte(CH_ZERO, 1'b0);
    put_byte(nib_char(b[7:4]), 1'b0);
    put_byte(nib_char(b[3:0]), 1'b0);
  endtask

  task automatic drop_hold();
    for (int k = 0; k < hold_cnt; k++) put_uesc(hold[k]);
    hold_cnt = 0;
    seq_need = 0;
  endtask

  task automatic take_fresh(input logic [7:0] b);
    if (b >= LEAD2_LO && b <= LEAD4_HI) begin
      hold[0] = b;
      hold_cnt = 1;
      seq_need = (b >= LEAD4_LO) ? 4 : (b >= LEAD3_LO) ? 3 : 2;
    end else if (b >= CONT_TAG || b < CTRL_LIMIT) begin
      put_uesc(b);
    end else if (b == CH_QUOTE || b == CH_BSL) begin
      put_byte(CH_BSL, 1'b0);
      put_byte(b, 1'b0);
    end else begin
      put_byte(b, 1'b0);
    end
  endtask

  // second byte limits only matter right after the lead
  function automatic logic extends_seq(input logic [7:0] b);
    if ((b & CONT_MASK) != CONT_TAG) return 1'b0;
    if (hold_cnt != 1) return 1'b1;
    case (hold[0])
      LEAD3_LO:  return b >= LIM_A0;
      LEAD_SURR: return b < LIM_A0;
      LEAD4_LO:  return b >= LIM_90;
      LEAD4_HI:  return b < LIM_90;
      default:   return 1'b1;
    endcase
  endfunction

  task automatic encode_item(input logic fn, input logic [7:0] b);
    lit_byte_t r;
    step_q.delete();
    if (!str_open) begin
      put_byte(CH_QUOTE, 1'b0);
      str_open = 1'b1;
    end
    if (fn == FN_END) begin
      drop_hold();
      put_byte(CH_QUOTE, 1'b1);
      str_open = 1'b0;
      n_strings++;
    end else if (hold_cnt == 0) begin
      take_fresh(b);
    end else if (extends_seq(b)) begin
      if (hold_cnt + 1 >= seq_need) begin
        for (int k = 0; k < hold_cnt; k++) put_byte(hold[k], 1'b0);
        put_byte(b, 1'b0);
        hold_cnt = 0;
        seq_need = 0;
      end else begin
        hold[hold_cnt] = b;
        hold_cnt++;
      end
    end else begin
      drop_hold();
      take_fresh(b);
    end
    if (step_q.size() > 0) begin
      r = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[k]) literal_q.push_back(step_q[k]);
  endtask

  task automatic add(input logic fn, input logic [7:0] b);
    str_item_t it;
    it.fn = fn;
    it.data = b;
    pending_items.push_back(it);
  endtask

  // multi-byte sequence, well formed up to keep bytes
  task automatic add_utf8(input int len, input int keep);
    logic [7:0] seq [4];
    logic [7:0] lo2;
    logic [7:0] hi2;
    int pick;
    pick = $urandom_range(3);
    case (len)
      2: seq[0] = 8'($urandom_range(LEAD2_HI, LEAD2_LO));
      3: seq[0] = (pick == 0) ? LEAD3_LO : (pick == 1) ? LEAD_SURR :
                  8'($urandom_range(LEAD3_HI, LEAD3_LO));
      default: seq[0] = (pick == 0) ? LEAD4_LO : (pick == 1) ? LEAD4_HI :
                        8'($urandom_range(LEAD4_HI, LEAD4_LO));
    endcase
    lo2 = CONT_TAG;
    hi2 = 8'hbf;
    if (seq[0] == LEAD3_LO) lo2 = LIM_A0;
    else if (seq[0] == LEAD_SURR) hi2 = LIM_A0 - 8'd1;
    else if (seq[0] == LEAD4_LO) lo2 = LIM_90;
    else if (seq[0] == LEAD4_HI) hi2 = LIM_90 - 8'd1;
    seq[1] = 8'($urandom_range(hi2, lo2));
    seq[2] = 8'($urandom_range(8'hbf, CONT_TAG));
    seq[3] = 8'($urandom_range(8'hbf, CONT_TAG));
    for (int k = 0; k < keep; k++) add(FN_DATA, seq[k]);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        encode_item(func, in_byte);
        n_in++;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
          in_valid <= 1'b1;
          func <= pending_items[0].fn;
          in_byte <= pending_items[0].data;
          void'(pending_items.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lit_byte_t exp_b;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (literal_q.size() == 0) begin
          $error("unexpected output byte %h", out_byte);
          n_errors++;
        end else begin
          exp_b = literal_q.pop_front();
          n_checked++;
          if (out_byte !== exp_b.b) begin
            $error("out_byte: expected %h, got %h", exp_b.b, out_byte);
            n_errors++;
          end
          if (last !== exp_b.last) begin
            $error("last: expected %b, got %b", exp_b.last, last);
            n_errors++;
          end
          if (closing !== exp_b.closing) begin
            $error("closing: expected %b, got %b", exp_b.closing, closing);
            n_errors++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  initial begin
    int n_directed;
    int nchunks;
    int r;
    int len;

    // plain, escaped and invalid single bytes
    add(FN_DATA, CH_QUOTE);
    add(FN_DATA, CH_BSL);
    add(FN_DATA, 8'h00);
    add(FN_DATA, 8'h1f);
    add(FN_DATA, CTRL_LIMIT);
    add(FN_DATA, 8'hc1);
    add(FN_DATA, 8'hff);
    add(FN_END, 8'hff);
    // empty string
    add(FN_END, 8'h00);
    // rejected second bytes after the boundary leads
    add(FN_DATA, LEAD3_LO);
    add(FN_DATA, 8'h9f);
    add(FN_DATA, LEAD_SURR);
    add(FN_DATA, LIM_A0);
    add(FN_DATA, LEAD4_LO);
    add(FN_DATA, 8'h8f);
    add(FN_DATA, LEAD4_HI);
    add(FN_DATA, LIM_90);
    // good two-byte sequence
    add(FN_DATA, LEAD2_HI);
    add(FN_DATA, 8'hbf);
    // three held bytes broken by an invalid byte
    add(FN_DATA, LEAD4_HI);
    add(FN_DATA, 8'h8f);
    add(FN_DATA, 8'hbf);
    add(FN_DATA, 8'hff);
    // truncated at the end marker
    add(FN_DATA, LEAD4_LO);
    add(FN_DATA, LIM_90);
    add(FN_DATA, CONT_TAG);
    add(FN_END, 8'h5a);
    n_directed = pending_items.size();

    while (pending_items.size() < n_directed + RANDOM_ITEMS) begin
      nchunks = $urandom_range(6);
      for (int c = 0; c < nchunks; c++) begin
        r = $urandom_range(99);
        len = $urandom_range(4, 2);
        if (r < 30) begin
          add(FN_DATA, 8'($urandom_range(8'h7f, CTRL_LIMIT)));
        end else if (r < 65) begin
          add_utf8(len, len);
        end else if (r < 75) begin
          case ($urandom_range(2))
            0: add(FN_DATA, CH_QUOTE);
            1: add(FN_DATA, CH_BSL);
            default: add(FN_DATA, 8'($urandom_range(8'h1f, 8'h00)));
          endcase
        end else if (r < 87) begin
          add_utf8(len, $urandom_range(len - 1, 1));
        end else begin
          add(FN_DATA, 8'($urandom_range(255)));
        end
      end
      add(FN_END, 8'($urandom_range(255)));
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || literal_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (literal_q.size() != 0) begin
      $error("%0d expected output bytes never arrived", literal_q.size());
      n_errors++;
    end
    $display("%0d items over %0d strings (%0d directed), %0d literal bytes checked",
             n_in, n_strings, n_directed, n_checked);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
